// ----- src/lookup3_hashlittle2_defines.svh -----
// assertion macros shared by the hash block's modules
`ifndef LOOKUP3_HASHLITTLE2_DEFINES_SVH
`define LOOKUP3_HASHLITTLE2_DEFINES_SVH

// property must hold at every clock edge outside reset
`define LH2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define LH2_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- src/lh2_pkg.sv -----
// types, constants and mix functions of the lookup3 hashlittle2 block
package lh2_pkg;

  localparam logic [31:0] HashInit   = 32'hDEADBEEF;
  localparam int unsigned GroupBytes = 12;
  localparam logic [3:0]  LastPos    = 4'd11;
  localparam logic [2:0]  GroupLastStep = 3'd5;
  localparam logic [2:0]  FinalLastStep = 3'd6;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] total_length;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] hash_high;
    logic [31:0] hash_low;
  } result_t;

  typedef enum logic [1:0] {
    CMD_EMPTY,
    CMD_MIX,
    CMD_FINAL
  } cmd_kind_e;

  // one entry of the queue between front and back
  typedef struct packed {
    cmd_kind_e    kind;
    logic         first;
    logic [31:0]  seed;
    logic [95:0]  group;
  } cmd_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GROUP,
    BK_FINAL,
    BK_OUT
  } back_state_e;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned k);
    logic [63:0] dbl;
    dbl = {v, v} << k;
    return dbl[63:32];
  endfunction

  // one line of the group mix per step
  function automatic words_t group_step(input logic [2:0] step, input words_t w);
    words_t r;
    r = w;
    unique case (step)
      3'd0: begin r.a = (w.a - w.c) ^ rotl(w.c, 4);  r.c = w.c + w.b; end
      3'd1: begin r.b = (w.b - w.a) ^ rotl(w.a, 6);  r.a = w.a + w.c; end
      3'd2: begin r.c = (w.c - w.b) ^ rotl(w.b, 8);  r.b = w.b + w.a; end
      3'd3: begin r.a = (w.a - w.c) ^ rotl(w.c, 16); r.c = w.c + w.b; end
      3'd4: begin r.b = (w.b - w.a) ^ rotl(w.a, 19); r.a = w.a + w.c; end
      3'd5: begin r.c = (w.c - w.b) ^ rotl(w.b, 4);  r.b = w.b + w.a; end
      default: r = w;
    endcase
    return r;
  endfunction

  // one line of the final mix per step
  function automatic words_t final_step(input logic [2:0] step, input words_t w);
    words_t r;
    r = w;
    unique case (step)
      3'd0: r.c = (w.c ^ w.b) - rotl(w.b, 14);
      3'd1: r.a = (w.a ^ w.c) - rotl(w.c, 11);
      3'd2: r.b = (w.b ^ w.a) - rotl(w.a, 25);
      3'd3: r.c = (w.c ^ w.b) - rotl(w.b, 16);
      3'd4: r.a = (w.a ^ w.c) - rotl(w.c, 4);
      3'd5: r.b = (w.b ^ w.a) - rotl(w.a, 14);
      3'd6: r.c = (w.c ^ w.b) - rotl(w.b, 24);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

// ----- src/lh2_front.sv -----
// byte collector: packs string bytes into 12-byte groups and issues commands
`include "lookup3_hashlittle2_defines.svh"

module lh2_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  lh2_pkg::item_t item_i,
  output logic           cmd_push_o,
  output lh2_pkg::cmd_t  cmd_o,
  input  logic           cmd_full_i
);

  logic        in_string_q, in_string_d;
  logic        first_q, first_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] seed_q, seed_d;
  logic [95:0] group_q, group_d;

  logic        accept;
  logic        cur_first;
  logic [31:0] cur_seed;
  logic [3:0]  cur_pos;
  logic [95:0] group_w;

  assign full_o = cmd_full_i;
  assign accept = push_i && !cmd_full_i;

  assign cur_first = in_string_q ? first_q : 1'b1;
  assign cur_seed  = in_string_q ? seed_q : lh2_pkg::HashInit + item_i.total_length;
  assign cur_pos   = in_string_q ? pos_q : 4'd0;

  // byte lands in its lane; unsent lanes stay zero
  always_comb begin
    group_w = group_q;
    for (int i = 0; i < lh2_pkg::GroupBytes; i++) begin
      if (cur_pos == 4'(i)) begin
        group_w[i*8 +: 8] = item_i.data_byte;
      end
    end
  end

  always_comb begin
    in_string_d = in_string_q;
    first_d     = first_q;
    pos_d       = pos_q;
    seed_d      = seed_q;
    group_d     = group_q;
    cmd_push_o  = 1'b0;
    cmd_o.kind  = lh2_pkg::CMD_MIX;
    cmd_o.first = cur_first;
    cmd_o.seed  = cur_seed;
    cmd_o.group = group_w;
    if (accept) begin
      if (!in_string_q && item_i.total_length == 32'd0) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = lh2_pkg::CMD_EMPTY;
      end else if (item_i.last) begin
        cmd_push_o  = 1'b1;
        cmd_o.kind  = lh2_pkg::CMD_FINAL;
        in_string_d = 1'b0;
        pos_d       = 4'd0;
        group_d     = '0;
      end else if (cur_pos == lh2_pkg::LastPos) begin
        cmd_push_o  = 1'b1;
        cmd_o.kind  = lh2_pkg::CMD_MIX;
        in_string_d = 1'b1;
        first_d     = 1'b0;
        seed_d      = cur_seed;
        pos_d       = 4'd0;
        group_d     = '0;
      end else begin
        in_string_d = 1'b1;
        first_d     = cur_first;
        seed_d      = cur_seed;
        pos_d       = cur_pos + 4'd1;
        group_d     = group_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      first_q     <= 1'b0;
      pos_q       <= 4'd0;
      group_q     <= '0;
    end else begin
      in_string_q <= in_string_d;
      first_q     <= first_d;
      pos_q       <= pos_d;
      group_q     <= group_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
  end

  `LH2_ASSERT(a_pos_range, pos_q <= lh2_pkg::LastPos, "byte position past group end")
  `LH2_ASSERT(a_idle_clean, !in_string_q |-> (pos_q == 4'd0 && group_q == '0),
              "group buffer not clean between strings")

endmodule

// ----- src/lh2_cmd_fifo.sv -----
// short command queue between byte collector and mix engine
`include "lookup3_hashlittle2_defines.svh"

module lh2_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lh2_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output lh2_pkg::cmd_t data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  lh2_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `LH2_ASSERT_NEVER(a_no_overflow, push_i && full_o, "command pushed into full queue")
  `LH2_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "command popped from empty queue")

endmodule

// ----- src/lh2_back.sv -----
// mix engine: one mix line per cycle, result held in an output register
`include "lookup3_hashlittle2_defines.svh"

module lh2_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_empty_i,
  input  lh2_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output lh2_pkg::result_t result_o
);

  lh2_pkg::back_state_e state_q, state_d;
  lh2_pkg::words_t      words_q, words_d, base;
  lh2_pkg::result_t     out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           step_q, step_d;
  logic                 out_take;

  assign out_take = pop_i && out_valid_q;
  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  always_comb begin
    state_d     = state_q;
    words_d     = words_q;
    step_d      = step_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_take;
    cmd_pop_o   = 1'b0;
    base        = cmd_i.first ? lh2_pkg::words_t'{a: cmd_i.seed, b: cmd_i.seed, c: cmd_i.seed}
                              : words_q;
    unique case (state_q)
      lh2_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          step_d    = 3'd0;
          if (cmd_i.kind == lh2_pkg::CMD_EMPTY) begin
            words_d = '{a: cmd_i.seed, b: cmd_i.seed, c: cmd_i.seed};
            state_d = lh2_pkg::BK_OUT;
          end else begin
            words_d.a = base.a + cmd_i.group[31:0];
            words_d.b = base.b + cmd_i.group[63:32];
            words_d.c = base.c + cmd_i.group[95:64];
            state_d   = (cmd_i.kind == lh2_pkg::CMD_MIX) ? lh2_pkg::BK_GROUP
                                                         : lh2_pkg::BK_FINAL;
          end
        end
      end
      lh2_pkg::BK_GROUP: begin
        words_d = lh2_pkg::group_step(step_q, words_q);
        step_d  = step_q + 3'd1;
        if (step_q == lh2_pkg::GroupLastStep) begin
          state_d = lh2_pkg::BK_IDLE;
        end
      end
      lh2_pkg::BK_FINAL: begin
        words_d = lh2_pkg::final_step(step_q, words_q);
        step_d  = step_q + 3'd1;
        if (step_q == lh2_pkg::FinalLastStep) begin
          state_d = lh2_pkg::BK_OUT;
        end
      end
      lh2_pkg::BK_OUT: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_take) begin
          out_d.hash_high = words_q.b;
          out_d.hash_low  = words_q.c;
          out_valid_d     = 1'b1;
          state_d         = lh2_pkg::BK_IDLE;
        end
      end
      default: state_d = lh2_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lh2_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= 3'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
    out_q   <= out_d;
  end

  `LH2_ASSERT(a_group_steps, state_q == lh2_pkg::BK_GROUP |-> step_q <= lh2_pkg::GroupLastStep,
              "group mix ran past its last line")
  `LH2_ASSERT(a_pop_only_idle, cmd_pop_o |-> state_q == lh2_pkg::BK_IDLE,
              "command taken while engine busy")

endmodule

// ----- src/lookup3_hashlittle2.sv -----
// top level of the streaming lookup3 hashlittle2 hash, seeds fixed at zero
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  input   | push_i / full_o    | item_i   : data_byte, total_length, last
//  result  | empty_o / pop_i    | result_o : hash_high (word b), hash_low (c)
//
// one byte is taken per cycle while the command queue has room
// every 12th byte, a last byte or an empty-string item becomes one command; the mix
//   engine runs the group mix lines for a group, the final mix lines plus a result
//   write for a final, a result write alone for an empty string; long strings run
//   at one byte per cycle while results are taken, short ones at final-mix pace
// one result waits in the output register while the next string is collected
// reset returns both sides to awaiting the first byte of a string
module lookup3_hashlittle2 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  lh2_pkg::item_t   item_i,
  output logic             empty_o,
  input  logic             pop_i,
  output lh2_pkg::result_t result_o
);

  lh2_pkg::cmd_t cmd_in, cmd_out;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;

  lh2_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .item_i     (item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  lh2_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  lh2_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .result_o    (result_o)
  );

endmodule

// ----- tb/sv/tb_lookup3_hashlittle2.sv -----
// self-checking testbench for the streaming lookup3 hashlittle2 block
module tb_lookup3_hashlittle2;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] SEED_BASE = 32'hDEADBEEF;
  localparam int unsigned GROUP_LEN = 12;
  localparam int unsigned PHASE_ITEMS = 60;
  localparam int unsigned HOLD_AT = 250;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH
  } phase_e;

  // one row of directed stimulus; typed marks a hash written in by hand
  typedef struct packed {
    lh2_pkg::item_t   item;
    logic             typed;
    lh2_pkg::result_t hash;
  } vec_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push_i = 1'b0;
  logic             pop_i = 1'b0;
  lh2_pkg::item_t   item_i = '0;
  logic             full_o;
  logic             empty_o;
  lh2_pkg::result_t result_o;

  // hash words of the string being collected
  logic [31:0] acc_a = '0;
  logic [31:0] acc_b = '0;
  logic [31:0] acc_c = '0;
  logic [3:0]  acc_pos = '0;
  logic        acc_open = 1'b0;

  lh2_pkg::result_t pending_hashes[$];
  phase_e  idle_phase = PH_STEADY;
  logic    hold_req = 1'b0;
  int      items_sent = 0;
  int      strings_sent = 0;
  int      hashes_checked = 0;
  int      errors = 0;

  vec_t directed_vecs [0:18] = '{
    // empty strings give the plain seed whatever last says
    {8'hFF, 32'h0, 1'b1, 1'b1, SEED_BASE, SEED_BASE},
    {8'h00, 32'h0, 1'b0, 1'b1, SEED_BASE, SEED_BASE},
    {8'h00, 32'd1, 1'b1, 1'b0, 64'h0},
    {8'hFF, 32'hFFFFFFFF, 1'b1, 1'b0, 64'h0},
    // twelve bytes ending on last: final mix only; seed length is wrong on purpose
    {8'hFF, 32'd5, 1'b0, 1'b0, 64'h0},
    {8'h00, 32'h0, 1'b0, 1'b0, 64'h0},
    {8'h80, 32'hFFFFFFFF, 1'b0, 1'b0, 64'h0},
    {8'h01, 32'h0, 1'b0, 1'b0, 64'h0},
    {8'hFF, 32'hFFFFFFFF, 1'b0, 1'b0, 64'h0},
    {8'hFF, 32'h0, 1'b0, 1'b0, 64'h0},
    {8'h00, 32'h5555AAAA, 1'b0, 1'b0, 64'h0},
    {8'h00, 32'hAAAA5555, 1'b0, 1'b0, 64'h0},
    {8'h7F, 32'h0, 1'b0, 1'b0, 64'h0},
    {8'hFE, 32'h0, 1'b0, 1'b0, 64'h0},
    {8'h55, 32'hFFFFFFFF, 1'b0, 1'b0, 64'h0},
    {8'hAA, 32'h0, 1'b1, 1'b0, 64'h0},
    {8'h5A, 32'h0, 1'b1, 1'b1, SEED_BASE, SEED_BASE},
    // seed claims more bytes than are sent
    {8'hC3, 32'h80000000, 1'b0, 1'b0, 64'h0},
    {8'h3C, 32'h0, 1'b1, 1'b0, 64'h0}
  };

  lookup3_hashlittle2 dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .item_i   (item_i),
    .empty_o  (empty_o),
    .pop_i    (pop_i),
    .result_o (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int k);
    return (v << k) | (v >> (32 - k));
  endfunction

  function automatic void mix_group();
    acc_a -= acc_c; acc_a ^= rol32(acc_c, 4);  acc_c += acc_b;
    acc_b -= acc_a; acc_b ^= rol32(acc_a, 6);  acc_a += acc_c;
    acc_c -= acc_b; acc_c ^= rol32(acc_b, 8);  acc_b += acc_a;
    acc_a -= acc_c; acc_a ^= rol32(acc_c, 16); acc_c += acc_b;
    acc_b -= acc_a; acc_b ^= rol32(acc_a, 19); acc_a += acc_c;
    acc_c -= acc_b; acc_c ^= rol32(acc_b, 4);  acc_b += acc_a;
  endfunction

  function automatic void mix_final();
    acc_c ^= acc_b; acc_c -= rol32(acc_b, 14);
    acc_a ^= acc_c; acc_a -= rol32(acc_c, 11);
    acc_b ^= acc_a; acc_b -= rol32(acc_a, 25);
    acc_c ^= acc_b; acc_c -= rol32(acc_b, 16);
    acc_a ^= acc_c; acc_a -= rol32(acc_c, 4);
    acc_b ^= acc_a; acc_b -= rol32(acc_a, 14);
    acc_c ^= acc_b; acc_c -= rol32(acc_b, 24);
  endfunction

  // folds one byte into the running hash; returns 1 when a hash comes out
  function automatic bit hash_byte(input lh2_pkg::item_t it, output lh2_pkg::result_t hash);
    logic [31:0] seed;
    logic [31:0] addend;
    hash = '0;
    if (!acc_open) begin
      seed = SEED_BASE + it.total_length;
      acc_a = seed;
      acc_b = seed;
      acc_c = seed;
      acc_pos = '0;
      if (it.total_length == 32'h0) begin
        hash.hash_high = seed;
        hash.hash_low = seed;
        return 1'b1;
      end
      acc_open = 1'b1;
    end
    addend = {24'h0, it.data_byte} << (8 * acc_pos[1:0]);
    case (acc_pos[3:2])
      2'd0: acc_a += addend;
      2'd1: acc_b += addend;
      default: acc_c += addend;
    endcase
    acc_pos = acc_pos + 4'd1;
    if (it.last) begin
      mix_final();
      hash.hash_high = acc_b;
      hash.hash_low = acc_c;
      acc_open = 1'b0;
      acc_pos = '0;
      return 1'b1;
    end
    if (acc_pos >= GROUP_LEN) begin
      mix_group();
      acc_pos = '0;
    end
    return 1'b0;
  endfunction

  function automatic void check_hash(input lh2_pkg::result_t got);
    lh2_pkg::result_t want;
    if (pending_hashes.size() == 0) begin
      errors++;
      $display("%0t: hash %h_%h with none expected", $time, got.hash_high, got.hash_low);
      return;
    end
    want = pending_hashes.pop_front();
    hashes_checked++;
    if (got.hash_high !== want.hash_high) begin
      errors++;
      $display("%0t: hash_high expected %h, got %h", $time, want.hash_high, got.hash_high);
    end
    if (got.hash_low !== want.hash_low) begin
      errors++;
      $display("%0t: hash_low expected %h, got %h", $time, want.hash_low, got.hash_low);
    end
  endfunction

  task automatic push_byte(input lh2_pkg::item_t it, input logic typed,
                           input lh2_pkg::result_t typed_hash);
    lh2_pkg::result_t h;
    int gap_pct;
    gap_pct = (idle_phase == PH_SEND_GAPS) ? 70 : (idle_phase == PH_BOTH) ? 23 : 0;
    while ($urandom_range(99) < gap_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    // transfer done at this edge
    if (hash_byte(it, h)) begin
      pending_hashes.push_back(typed ? typed_hash : h);
    end
    if (it.last || !acc_open) strings_sent++;
    items_sent++;
    idle_phase = phase_e'((items_sent / PHASE_ITEMS) % 4);
    if (items_sent == HOLD_AT) hold_req = 1'b1;
  endtask

  task automatic send_string();
    int len;
    int pick;
    logic [31:0] seed_len;
    lh2_pkg::item_t it;
    pick = $urandom_range(99);
    if (pick < 8) len = 0;
    else if (pick < 70) len = $urandom_range(13, 1);
    else if (pick < 90) len = $urandom_range(40, 14);
    else len = $urandom_range(100, 41);
    // now and then the length on the first byte does not match
    seed_len = ($urandom_range(9) == 0) ? $urandom : len;
    if (len == 0) begin
      it.data_byte = 8'($urandom);
      it.total_length = 32'h0;
      it.last = 1'($urandom);
      push_byte(it, 1'b0, '0);
    end else begin
      for (int i = 0; i < len; i++) begin
        it.data_byte = 8'($urandom);
        it.total_length = (i == 0) ? seed_len : $urandom;
        it.last = (i == len - 1);
        push_byte(it, 1'b0, '0);
      end
    end
  endtask

  // result side: random stalls by phase, one long hold to back the block up
  initial begin : drain
    int hold_left;
    int stall_pct;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) check_hash(result_o);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      stall_pct = (idle_phase == PH_RECV_STALLS) ? 70 : (idle_phase == PH_BOTH) ? 23 : 0;
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    vec_t row;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(directed_vecs); i++) begin
      row = directed_vecs[i];
      push_byte(row.item, row.typed, row.hash);
    end
    while (items_sent < 450) send_string();
    push_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("hashed %0d bytes in %0d strings, compared %0d hashes, %0d mismatches",
             items_sent, strings_sent, hashes_checked, errors);
    $display("idle mixes on both sides plus one %0d-cycle result hold", HOLD_CYCLES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("timeout with %0d hashes outstanding", pending_hashes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
